// ----- rtl/crdm_pkg.sv -----
// Package for the compression rate and depth monitor.
// Field widths, register reset values and register indexes; no dependencies.
`timescale 1ns / 1ps

package crdm_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int RATE_W  = 8;
    localparam int DEPTH_W = 8;
    localparam int GAP_W   = 8;
    localparam int SEC_W   = 16;
    localparam int STEP_W  = 6;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;

    // compressions per minute = RATE_MUL * presses / seconds
    localparam int RATE_MUL = 60;

    localparam logic [GAP_W-1:0]   SAMPLE_GAP_RST = GAP_W'(3);
    localparam logic [SEC_W-1:0]   SECOND_MS_RST  = SEC_W'(1000);
    localparam logic [GAP_W-1:0]   RAMP_GAP_RST   = GAP_W'(15);
    localparam logic [STEP_W-1:0]  DEPTH_STEP_RST = STEP_W'(3);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX_RST  = DEPTH_W'(50);
    localparam logic [RATE_W-1:0]  RATE_LIMIT_RST = RATE_W'(160);
    localparam logic [RATE_W-1:0]  RATE_RST       = RATE_W'(100);

    typedef enum logic [2:0] {
        CFG_SAMPLE_GAP = 3'd0,
        CFG_SECOND_MS  = 3'd1,
        CFG_RAMP_GAP   = 3'd2,
        CFG_DEPTH_STEP = 3'd3,
        CFG_DEPTH_MAX  = 3'd4,
        CFG_RATE_LIMIT = 3'd5
    } cfg_index_t;

endpackage

// ----- rtl/crdm_in_if.sv -----
// Tick channel: one item per millisecond with the button and link levels.
// Depends on nothing.
`timescale 1ns / 1ps

interface crdm_in_if;
    logic valid;
    logic ready;
    logic compress_button;
    logic hand_button;
    logic link_up;

    modport source (output valid, output compress_button, output hand_button,
                    output link_up, input ready);
    modport sink   (input valid, input compress_button, input hand_button,
                    input link_up, output ready);
endinterface

// ----- rtl/crdm_out_if.sv -----
// Report channel: rate, depth and hand level of one report.
// Depends on crdm_pkg for the field widths.
`timescale 1ns / 1ps

interface crdm_out_if;
    logic                         valid;
    logic                         ready;
    logic [crdm_pkg::RATE_W-1:0]  rate_per_min;
    logic [crdm_pkg::DEPTH_W-1:0] depth;
    logic                         hand_on;

    modport source (output valid, output rate_per_min, output depth, output hand_on,
                    input ready);
    modport sink   (input valid, input rate_per_min, input depth, input hand_on,
                    output ready);
endinterface

// ----- rtl/compression_rate_depth_monitor.sv -----
// Compression rate and depth monitor, top level.
// Depends on crdm_pkg, crdm_in_if and crdm_out_if.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------
//  tick     | in  | valid/ready          | compress_button, hand_button, link_up
//  report   | out | valid/ready          | rate_per_min, depth, hand_on
//  cfg      | in  | cfg_we, no wait      | cfg_index, cfg_data
//
// An item without a report passes the gap and link steps; a report also passes
// the second, press and ramp steps, and a press with a nonzero second count
// adds the division and the rate cap: the rate quotient comes from a restoring
// divider, one bit a cycle.
// One 32-bit subtract-compare unit checks all three time gaps in turn.
// The report register holds a result until taken; a new item is accepted
// meanwhile, and stalls only when it has a report of its own to post.
// rst_n clears all control state and loads the register defaults.
`timescale 1ns / 1ps

module compression_rate_depth_monitor #(
    parameter int COUNT_BITS = crdm_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    crdm_in_if.sink                    tick,
    crdm_out_if.source                 report,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [crdm_pkg::CFG_W-1:0] cfg_data
);

    localparam int TW    = crdm_pkg::TIME_W;
    localparam int DIV_W = COUNT_BITS + $clog2(crdm_pkg::RATE_MUL);
    localparam int CNT_W = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_SEC,
        S_PRESS,
        S_DIV,
        S_CAP,
        S_RAMP,
        S_LINK
    } state_t;

    state_t state_reg;

    // configuration
    logic [crdm_pkg::GAP_W-1:0]   sample_gap_reg;
    logic [crdm_pkg::SEC_W-1:0]   second_ms_reg;
    logic [crdm_pkg::GAP_W-1:0]   ramp_gap_reg;
    logic [crdm_pkg::STEP_W-1:0]  depth_step_reg;
    logic [crdm_pkg::DEPTH_W-1:0] depth_max_reg;
    logic [crdm_pkg::RATE_W-1:0]  rate_limit_reg;

    // block state
    logic [TW-1:0]                now_reg;
    logic [TW-1:0]                last_report_reg;
    logic [TW-1:0]                last_second_reg;
    logic [TW-1:0]                last_ramp_reg;
    logic [COUNT_BITS-1:0]        elapsed_reg;
    logic [COUNT_BITS-1:0]        press_reg;
    logic [crdm_pkg::RATE_W-1:0]  rate_reg;
    logic [crdm_pkg::DEPTH_W-1:0] depth_reg;
    logic                         prev_comp_reg;
    logic                         prev_link_reg;

    // latched item and divider datapath
    logic                         comp_reg;
    logic                         hand_reg;
    logic                         link_reg;
    logic [DIV_W-1:0]             dq_reg;
    logic [COUNT_BITS-1:0]        rem_reg;
    logic [CNT_W-1:0]             cnt_reg;

    // report register
    logic                         out_valid_reg;
    logic [crdm_pkg::RATE_W-1:0]  out_rate_reg;
    logic [crdm_pkg::DEPTH_W-1:0] out_depth_reg;
    logic                         out_hand_reg;

    // shared gap unit
    logic [TW-1:0]                since;
    logic [TW-1:0]                gap;
    logic [TW-1:0]                diff;
    logic                         gap_passed;

    logic [COUNT_BITS-1:0]        press_inc;
    logic [DIV_W-1:0]             dividend;
    logic [COUNT_BITS:0]          rem_sh;
    logic                         rem_ge;
    logic [COUNT_BITS:0]          rem_sub;
    logic [crdm_pkg::DEPTH_W:0]   depth_up;
    logic [crdm_pkg::DEPTH_W-1:0] depth_ramped;
    logic                         out_free;
    logic                         press_edge;

    always_comb
    begin
        since = last_report_reg;
        gap   = TW'(sample_gap_reg);
        case (state_reg)
            S_SEC:
            begin
                since = last_second_reg;
                gap   = TW'(second_ms_reg);
            end
            S_RAMP:
            begin
                since = last_ramp_reg;
                gap   = TW'(ramp_gap_reg);
            end
            default:
            begin
                since = last_report_reg;
                gap   = TW'(sample_gap_reg);
            end
        endcase
        diff       = now_reg - since;
        gap_passed = diff > gap;
    end

    assign press_edge = comp_reg && !prev_comp_reg;
    assign press_inc  = (press_reg != '1) ? press_reg + 1'b1 : press_reg;
    assign dividend   = DIV_W'(press_inc) * DIV_W'(crdm_pkg::RATE_MUL);

    assign rem_sh  = {rem_reg, dq_reg[DIV_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, elapsed_reg};
    assign rem_sub = rem_sh - {1'b0, elapsed_reg};

    always_comb
    begin
        depth_up = {1'b0, depth_reg} + (crdm_pkg::DEPTH_W + 1)'(depth_step_reg);
        if (comp_reg)
        begin
            if (depth_reg < depth_max_reg)
                depth_ramped = (depth_up > {1'b0, depth_max_reg}) ? depth_max_reg
                                                                    : depth_up[crdm_pkg::DEPTH_W-1:0];
            else
                depth_ramped = depth_reg;
        end
        else
        begin
            depth_ramped = (depth_reg > crdm_pkg::DEPTH_W'(depth_step_reg))
                           ? depth_reg - crdm_pkg::DEPTH_W'(depth_step_reg) : '0;
        end
    end

    assign out_free = !out_valid_reg || report.ready;

    assign tick.ready          = (state_reg == S_IDLE);
    assign report.valid        = out_valid_reg;
    assign report.rate_per_min = out_rate_reg;
    assign report.depth        = out_depth_reg;
    assign report.hand_on      = out_hand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sample_gap_reg  <= crdm_pkg::SAMPLE_GAP_RST;
            second_ms_reg   <= crdm_pkg::SECOND_MS_RST;
            ramp_gap_reg    <= crdm_pkg::RAMP_GAP_RST;
            depth_step_reg  <= crdm_pkg::DEPTH_STEP_RST;
            depth_max_reg   <= crdm_pkg::DEPTH_MAX_RST;
            rate_limit_reg  <= crdm_pkg::RATE_LIMIT_RST;
            now_reg         <= '0;
            last_report_reg <= '0;
            last_second_reg <= '0;
            last_ramp_reg   <= '0;
            elapsed_reg     <= '0;
            press_reg       <= '0;
            rate_reg        <= crdm_pkg::RATE_RST;
            depth_reg       <= '0;
            prev_comp_reg   <= 1'b0;
            prev_link_reg   <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_rate_reg    <= '0;
            out_depth_reg   <= '0;
            out_hand_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    crdm_pkg::CFG_SAMPLE_GAP: sample_gap_reg <= cfg_data[crdm_pkg::GAP_W-1:0];
                    crdm_pkg::CFG_SECOND_MS:  second_ms_reg  <= cfg_data[crdm_pkg::SEC_W-1:0];
                    crdm_pkg::CFG_RAMP_GAP:   ramp_gap_reg   <= cfg_data[crdm_pkg::GAP_W-1:0];
                    crdm_pkg::CFG_DEPTH_STEP: depth_step_reg <= cfg_data[crdm_pkg::STEP_W-1:0];
                    crdm_pkg::CFG_DEPTH_MAX:  depth_max_reg  <= cfg_data[crdm_pkg::DEPTH_W-1:0];
                    crdm_pkg::CFG_RATE_LIMIT: rate_limit_reg <= cfg_data[crdm_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end

            // S_RAMP reloads the report register itself
            if (report.ready && state_reg != S_RAMP)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick.valid)
                    begin
                        now_reg   <= now_reg + 1'b1;
                        state_reg <= S_GAP;
                    end
                end
                S_GAP:
                begin
                    state_reg <= (link_reg && gap_passed) ? S_SEC : S_LINK;
                end
                S_SEC:
                begin
                    if (gap_passed)
                    begin
                        last_second_reg <= now_reg;
                        if (elapsed_reg != '1)
                            elapsed_reg <= elapsed_reg + 1'b1;
                    end
                    state_reg <= S_PRESS;
                end
                S_PRESS:
                begin
                    prev_comp_reg <= comp_reg;
                    if (press_edge)
                    begin
                        press_reg <= press_inc;
                        if (elapsed_reg == '0)
                        begin
                            rate_reg  <= rate_limit_reg;
                            state_reg <= S_RAMP;
                        end
                        else
                        begin
                            cnt_reg   <= CNT_W'(DIV_W);
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RAMP;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= S_CAP;
                end
                S_CAP:
                begin
                    rate_reg  <= (dq_reg > DIV_W'(rate_limit_reg))
                                 ? rate_limit_reg : dq_reg[crdm_pkg::RATE_W-1:0];
                    state_reg <= S_RAMP;
                end
                S_RAMP:
                begin
                    // hold here until the report register is free
                    if (out_free)
                    begin
                        if (gap_passed)
                        begin
                            last_ramp_reg <= now_reg;
                            depth_reg     <= depth_ramped;
                        end
                        last_report_reg <= now_reg;
                        out_valid_reg   <= 1'b1;
                        out_rate_reg    <= rate_reg;
                        out_depth_reg   <= gap_passed ? depth_ramped : depth_reg;
                        out_hand_reg    <= hand_reg;
                        state_reg       <= S_LINK;
                    end
                end
                S_LINK:
                begin
                    prev_link_reg <= link_reg;
                    if (!link_reg && prev_link_reg)
                    begin
                        rate_reg    <= '0;
                        press_reg   <= '0;
                        elapsed_reg <= '0;
                    end
                    if (link_reg && !prev_link_reg)
                        last_report_reg <= now_reg;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers: latched item and divider datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && tick.valid)
        begin
            comp_reg <= tick.compress_button;
            hand_reg <= tick.hand_button;
            link_reg <= tick.link_up;
        end
        if (state_reg == S_PRESS)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            dq_reg  <= {dq_reg[DIV_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        end
    end

endmodule

// ----- tb/crdm_report_checker.sv -----
// Report checker for the compression rate and depth monitor.
// Watches the tick, report and register write ports, predicts every report
// and compares it field by field. Depends on crdm_pkg, crdm_in_if, crdm_out_if.
`timescale 1ns / 1ps

module crdm_report_checker #(
    parameter int COUNT_BITS = crdm_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    crdm_in_if                         tick,
    crdm_out_if                        report,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [crdm_pkg::CFG_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending
);
    import crdm_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [DEPTH_W-1:0] depth;
        logic               hand;
    } report_t;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam int                    EXP_DEPTH = 16;

    // register copies
    logic [GAP_W-1:0]   sample_gap;
    logic [SEC_W-1:0]   second_ms;
    logic [GAP_W-1:0]   ramp_gap;
    logic [STEP_W-1:0]  step;
    logic [DEPTH_W-1:0] depth_max;
    logic [RATE_W-1:0]  rate_limit;

    logic [TIME_W-1:0]     now_ms, last_report, last_second, last_ramp;
    logic [COUNT_BITS-1:0] seconds, presses;
    logic [RATE_W-1:0]     rate;
    logic [DEPTH_W-1:0]    depth_lvl;
    logic                  prev_comp, prev_link;

    // ring of predicted reports in order
    report_t    exp_store [EXP_DEPTH];
    logic [3:0] exp_wr;
    logic [3:0] exp_rd;
    int         exp_fill;

    // wrapping "more than gap ms since"
    function automatic logic gap_over(input logic [TIME_W-1:0] since,
                                      input logic [SEC_W-1:0] gap);
        logic [TIME_W-1:0] diff;
        diff = now_ms - since;
        return diff > TIME_W'(gap);
    endfunction

    task automatic step_millisecond(input logic comp, input logic hand, input logic link);
        logic [63:0]        quot;
        logic [DEPTH_W:0]   raised;
        report_t            rpt;
        now_ms = now_ms + 1'b1;
        if (link && gap_over(last_report, SEC_W'(sample_gap)))
        begin
            if (gap_over(last_second, second_ms))
            begin
                last_second = now_ms;
                if (seconds != COUNT_TOP)
                    seconds = seconds + 1'b1;
            end
            if (comp && !prev_comp)
            begin
                if (presses != COUNT_TOP)
                    presses = presses + 1'b1;
                if (seconds == '0)
                    rate = rate_limit;
                else
                begin
                    quot = (64'(RATE_MUL) * 64'(presses)) / 64'(seconds);
                    rate = (quot > 64'(rate_limit)) ? rate_limit : RATE_W'(quot);
                end
            end
            prev_comp = comp;
            if (gap_over(last_ramp, SEC_W'(ramp_gap)))
            begin
                last_ramp = now_ms;
                if (comp)
                begin
                    // depth above the ceiling is held while pressed
                    if (depth_lvl < depth_max)
                    begin
                        raised = {1'b0, depth_lvl} + (DEPTH_W+1)'(step);
                        depth_lvl = (raised > {1'b0, depth_max}) ? depth_max
                                                                 : raised[DEPTH_W-1:0];
                    end
                end
                else
                    depth_lvl = (depth_lvl > DEPTH_W'(step)) ? depth_lvl - DEPTH_W'(step) : '0;
            end
            last_report = now_ms;
            rpt.rate  = rate;
            rpt.depth = depth_lvl;
            rpt.hand  = hand;
            if (exp_fill == EXP_DEPTH)
            begin
                $error("too many reports outstanding");
                errors++;
            end
            else
            begin
                exp_store[exp_wr] = rpt;
                exp_wr            = exp_wr + 1'b1;
                exp_fill++;
            end
        end
        if (!link && prev_link)
        begin
            prev_link = 1'b0;
            rate      = '0;
            presses   = '0;
            seconds   = '0;
        end
        if (link && !prev_link)
        begin
            prev_link   = 1'b1;
            last_report = now_ms;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            sample_gap  = SAMPLE_GAP_RST;
            second_ms   = SECOND_MS_RST;
            ramp_gap    = RAMP_GAP_RST;
            step        = DEPTH_STEP_RST;
            depth_max   = DEPTH_MAX_RST;
            rate_limit  = RATE_LIMIT_RST;
            now_ms      = '0;
            last_report = '0;
            last_second = '0;
            last_ramp   = '0;
            seconds     = '0;
            presses     = '0;
            rate        = RATE_RST;
            depth_lvl   = '0;
            prev_comp   = 1'b0;
            prev_link   = 1'b0;
            exp_wr      = '0;
            exp_rd      = '0;
            exp_fill    = 0;
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (report.valid && report.ready)
            begin
                if (exp_fill == 0)
                begin
                    $error("unexpected report: rate_per_min %0d depth %0d hand_on %0d",
                           report.rate_per_min, report.depth, report.hand_on);
                    errors++;
                end
                else
                begin
                    want   = exp_store[exp_rd];
                    exp_rd = exp_rd + 1'b1;
                    exp_fill--;
                    if (report.rate_per_min !== want.rate)
                    begin
                        $error("rate_per_min: expected %0d, got %0d",
                               want.rate, report.rate_per_min);
                        errors++;
                    end
                    if (report.depth !== want.depth)
                    begin
                        $error("depth: expected %0d, got %0d", want.depth, report.depth);
                        errors++;
                    end
                    if (report.hand_on !== want.hand)
                    begin
                        $error("hand_on: expected %0d, got %0d", want.hand, report.hand_on);
                        errors++;
                    end
                end
            end
            if (tick.valid && tick.ready)
                step_millisecond(tick.compress_button, tick.hand_button, tick.link_up);
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SAMPLE_GAP: sample_gap = cfg_data[GAP_W-1:0];
                    CFG_SECOND_MS:  second_ms  = cfg_data[SEC_W-1:0];
                    CFG_RAMP_GAP:   ramp_gap   = cfg_data[GAP_W-1:0];
                    CFG_DEPTH_STEP: step       = cfg_data[STEP_W-1:0];
                    CFG_DEPTH_MAX:  depth_max  = cfg_data[DEPTH_W-1:0];
                    CFG_RATE_LIMIT: rate_limit = cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            pending = exp_fill;
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the compression rate and depth monitor.
// Drives ticks and register writes, stalls the report side, and gives the
// verdict from the checker's error count. Depends on crdm_pkg, the channel
// interfaces, compression_rate_depth_monitor and crdm_report_checker.
`timescale 1ns / 1ps

module tb;
    import crdm_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 40;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               errors;
    int               pending;
    bit               quiet;

    // random run state for well-formed button and link sequences
    logic comp_level, link_level;
    int   comp_run, link_run;

    crdm_in_if  tick();
    crdm_out_if report();

    compression_rate_depth_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .report    (report),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crdm_report_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .report    (report),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // report side back-pressure
    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        report.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cnt == 0 && !quiet && $urandom_range(0, 3) == 0)
                hold_cnt = pick_gap();
            if (hold_cnt > 0)
            begin
                report.ready <= 1'b0;
                hold_cnt--;
            end
            else
                report.ready <= 1'b1;
        end
    end

    // starts and ends at a falling edge
    task automatic send_tick(input logic comp, input logic hand, input logic link);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            tick.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick.valid           <= 1'b1;
        tick.compress_button <= comp;
        tick.hand_button     <= hand;
        tick.link_up         <= link;
        do
            @(posedge clk);
        while (!tick.ready);
        @(negedge clk);
    endtask

    task automatic wait_reports_done(input int settle);
        tick.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic load_config(input int gap, input int sec, input int ramp,
                               input int dstep, input int dmax, input int limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAMPLE_GAP;
        cfg_data  <= CFG_W'(gap);
        @(negedge clk);
        cfg_index <= CFG_SECOND_MS;
        cfg_data  <= CFG_W'(sec);
        @(negedge clk);
        cfg_index <= CFG_RAMP_GAP;
        cfg_data  <= CFG_W'(ramp);
        @(negedge clk);
        cfg_index <= CFG_DEPTH_STEP;
        cfg_data  <= CFG_W'(dstep);
        @(negedge clk);
        cfg_index <= CFG_DEPTH_MAX;
        cfg_data  <= CFG_W'(dmax);
        @(negedge clk);
        cfg_index <= CFG_RATE_LIMIT;
        cfg_data  <= CFG_W'(limit);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // button held in runs, link up for long stretches, occasional glitches
    task automatic send_session_tick();
        logic comp;
        if (comp_run == 0)
        begin
            comp_level = ~comp_level;
            comp_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
        end
        comp_run--;
        if (link_run == 0)
        begin
            link_level = ~link_level;
            link_run = link_level ? $urandom_range(30, 400) : $urandom_range(1, 6);
        end
        link_run--;
        comp = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : comp_level;
        send_tick(comp, 1'($urandom_range(0, 1)), link_level);
    endtask

    initial
    begin
        int p;
        rst_n                = 1'b0;
        quiet                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_SAMPLE_GAP;
        cfg_data             = '0;
        tick.valid           = 1'b0;
        tick.compress_button = 1'b0;
        tick.hand_button     = 1'b0;
        tick.link_up         = 1'b0;
        comp_level           = 1'b0;
        link_level           = 1'b0;
        comp_run             = 0;
        link_run             = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default registers: ticks while down, link gain, press with no
        // elapsed second, then link loss
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_reports_done(SETTLE_CYCLES);

        // report every tick, big steps into the depth ceiling, rate limit at its top value
        load_config(0, 1, 0, 63, 255, 255);
        send_tick(1'b1, 1'b0, 1'b1);
        repeat (5) send_tick(1'b1, 1'b1, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        wait_reports_done(SETTLE_CYCLES);

        for (p = 0; p < PHASES; p++)
        begin
            quiet = (p == 1 || p == 5);
            case (p)
                0: load_config(255, 65535, 255, 1, 1, 1);
                1: load_config(0, 1, 0, 63, 255, 255);
                2: load_config(SAMPLE_GAP_RST, SECOND_MS_RST, RAMP_GAP_RST,
                               DEPTH_STEP_RST, DEPTH_MAX_RST, RATE_LIMIT_RST);
                default: load_config($urandom_range(0, 6), $urandom_range(1, 40),
                                     $urandom_range(0, 8), $urandom_range(1, 63),
                                     $urandom_range(1, 255), $urandom_range(1, 255));
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // sender holds off until every report is out
                if (p == 3 && i == ITEMS_PER_PHASE / 2)
                    wait_reports_done(0);
                send_session_tick();
            end
            wait_reports_done(SETTLE_CYCLES);
        end

        quiet = 1'b0;
        wait_reports_done(60);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
